// ----- rtl/jst_pkg.sv -----
// Shared types, codes and literal tables for the JSON stream tokenizer.
package jst_pkg;

   localparam int MAX_DEPTH_DEF = 32;

   localparam int BYTE_W  = 8;
   localparam int EVENT_W = 5;
   localparam int DEPTH_W = 6;

   typedef enum logic [EVENT_W-1:0] {
      EV_SKIP        = 5'd0,
      EV_OBJ_OPEN    = 5'd1,
      EV_OBJ_CLOSE   = 5'd2,
      EV_ARR_OPEN    = 5'd3,
      EV_ARR_CLOSE   = 5'd4,
      EV_KEY_CHAR    = 5'd5,
      EV_KEY_END     = 5'd6,
      EV_COLON       = 5'd7,
      EV_COMMA       = 5'd8,
      EV_STR_OPEN    = 5'd9,
      EV_STR_CHAR    = 5'd10,
      EV_STR_CLOSE   = 5'd11,
      EV_KEY_OPEN    = 5'd12,
      EV_NUM_CHAR    = 5'd13,
      EV_LIT_CHAR    = 5'd14,
      EV_ESCAPE      = 5'd15,
      EV_ERROR       = 5'd16,
      EV_AFTER_ERROR = 5'd17
   } tok_event_type;

   typedef enum logic [1:0] {
      LIT_NONE  = 2'd0,
      LIT_TRUE  = 2'd1,
      LIT_FALSE = 2'd2,
      LIT_NULL  = 2'd3
   } lit_kind_type;

   // Container kinds as held on the stack.
   localparam logic KIND_OBJ = 1'b0;
   localparam logic KIND_ARR = 1'b1;

   typedef struct packed {
      logic push;
      logic pop;
      logic kind;
   } stack_op_type;

   typedef struct packed {
      logic empty;
      logic one;
      logic full;
      logic top_kind;
   } stack_status_type;

   typedef struct packed {
      tok_event_type      event_res;
      logic [BYTE_W-1:0]  data_byte;
      logic               number_done;
      lit_kind_type       literal_kind;
      logic               error_flag;
      logic               complete;
   } result_type;

   function automatic logic [2:0] lit_len(input lit_kind_type which);
      case (which)
         LIT_TRUE:  lit_len = 3'd4;
         LIT_FALSE: lit_len = 3'd5;
         LIT_NULL:  lit_len = 3'd4;
         default:   lit_len = 3'd0;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] lit_char(input lit_kind_type which,
                                                  input logic [2:0] pos);
      logic [BYTE_W-1:0] ch;
      ch = 8'h00;
      case (which)
         LIT_TRUE: begin
            case (pos)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            case (pos)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               3'd4:    ch = "e";
               default: ch = 8'h00;
            endcase
         end
         LIT_NULL: begin
            case (pos)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      lit_char = ch;
   endfunction

endpackage

// ----- rtl/jst_stack.sv -----
// Container-kind stack with a registered top-of-stack copy.
module jst_stack #(
   parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  jst_pkg::stack_op_type            op,
   output jst_pkg::stack_status_type        status,
   output logic [$clog2(MAX_DEPTH+1)-1:0]   depth,
   output logic [$clog2(MAX_DEPTH+1)-1:0]   depth_next
);

   localparam int SP_W  = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [SP_W-1:0]  rd_ptr;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             top_ff;
   logic             kind_mem [MAX_DEPTH];

   always_comb begin
      sp_in = sp_ff;
      if (op.push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (op.pop) begin
         sp_in = sp_ff - SP_W'(1);
      end
   end

   assign rd_ptr  = sp_in - SP_W'(1);
   assign rd_addr = rd_ptr[IDX_W-1:0];
   assign wr_addr = sp_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         kind_mem[wr_addr] <= op.kind;
      end
   end

   // Prefetch the entry that becomes the top; bypass the word pushed now.
   always_ff @(posedge clock) begin
      if (op.push) begin
         top_ff <= op.kind;
      end else begin
         top_ff <= kind_mem[rd_addr];
      end
   end

   assign status.empty    = (sp_ff == '0);
   assign status.one      = (sp_ff == SP_W'(1));
   assign status.full     = (sp_ff == SP_W'(MAX_DEPTH));
   assign status.top_kind = top_ff;
   assign depth           = sp_ff;
   assign depth_next      = sp_in;

endmodule

// ----- rtl/jst_parser.sv -----
// Grammar state machine: one byte in, one token result out.
module jst_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [jst_pkg::BYTE_W-1:0]    in_byte,
   input  jst_pkg::stack_status_type     stk,
   output jst_pkg::stack_op_type         stk_op,
   output jst_pkg::result_type           result,
   output logic                          error_now
);

   typedef enum logic [3:0] {
      ST_INIT      = 4'd0,
      ST_OBJ_START = 4'd1,
      ST_KEY       = 4'd2,
      ST_KEY_END   = 4'd3,
      ST_COLON     = 4'd4,
      ST_ARR_START = 4'd5,
      ST_NUM       = 4'd6,
      ST_STR       = 4'd7,
      ST_VALUE_END = 4'd8,
      ST_LIT       = 4'd9,
      ST_ERROR     = 4'd10
   } state_type;

   state_type              state_ff, state_in;
   logic                   esc_ff, esc_in;
   logic [2:0]             lpos_ff, lpos_in;
   jst_pkg::lit_kind_type  lwhich_ff, lwhich_in;
   logic                   done_ff, done_in;

   logic [7:0]             c;
   logic                   is_space, is_digit, in_value;

   // Start-of-value candidate
   jst_pkg::tok_event_type sv_ev;
   state_type              sv_st;
   logic                   sv_push, sv_arr;
   jst_pkg::lit_kind_type  sv_lw;

   // After-value candidate
   jst_pkg::tok_event_type av_ev;
   state_type              av_st;
   logic                   av_pop;

   jst_pkg::tok_event_type ev;
   logic [7:0]             data;
   logic                   numdone;
   jst_pkg::lit_kind_type  kind;
   logic                   push, pop, push_kind;
   logic                   is_key;
   logic [2:0]             lpos_inc;

   assign c        = in_byte;
   assign is_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   assign is_digit = c inside {[8'h30:8'h39]};
   assign in_value = state_ff inside {ST_NUM, ST_STR, ST_KEY, ST_LIT};
   assign lpos_inc = lpos_ff + 3'd1;

   always_comb begin
      sv_ev   = jst_pkg::EV_ERROR;
      sv_st   = ST_ERROR;
      sv_push = 1'b0;
      sv_arr  = 1'b0;
      sv_lw   = jst_pkg::LIT_NONE;
      if (c == "{" || c == "[") begin
         if (!stk.full) begin
            sv_push = 1'b1;
            sv_arr  = (c == "[");
            sv_st   = sv_arr ? ST_ARR_START : ST_OBJ_START;
            sv_ev   = sv_arr ? jst_pkg::EV_ARR_OPEN : jst_pkg::EV_OBJ_OPEN;
         end
      end else if (c == "-" || is_digit) begin
         sv_st = ST_NUM;
         sv_ev = jst_pkg::EV_NUM_CHAR;
      end else if (c == "\"") begin
         sv_st = ST_STR;
         sv_ev = jst_pkg::EV_STR_OPEN;
      end else if (c == "t" || c == "f" || c == "n") begin
         sv_st = ST_LIT;
         sv_ev = jst_pkg::EV_LIT_CHAR;
         sv_lw = (c == "t") ? jst_pkg::LIT_TRUE :
                 (c == "f") ? jst_pkg::LIT_FALSE : jst_pkg::LIT_NULL;
      end
   end

   always_comb begin
      av_ev  = jst_pkg::EV_ERROR;
      av_st  = ST_ERROR;
      av_pop = 1'b0;
      if (is_space) begin
         av_ev = jst_pkg::EV_SKIP;
         av_st = ST_VALUE_END;
      end else if (!stk.empty) begin
         if (c == ",") begin
            av_ev = jst_pkg::EV_COMMA;
            av_st = (stk.top_kind == jst_pkg::KIND_ARR) ? ST_ARR_START : ST_OBJ_START;
         end else if (stk.top_kind == jst_pkg::KIND_OBJ && c == "}") begin
            av_ev  = jst_pkg::EV_OBJ_CLOSE;
            av_st  = ST_VALUE_END;
            av_pop = 1'b1;
         end else if (stk.top_kind == jst_pkg::KIND_ARR && c == "]") begin
            av_ev  = jst_pkg::EV_ARR_CLOSE;
            av_st  = ST_VALUE_END;
            av_pop = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      esc_in    = esc_ff;
      lpos_in   = lpos_ff;
      lwhich_in = lwhich_ff;
      done_in   = done_ff;
      ev        = jst_pkg::EV_SKIP;
      data      = 8'h00;
      numdone   = 1'b0;
      kind      = jst_pkg::LIT_NONE;
      push      = 1'b0;
      pop       = 1'b0;
      push_kind = jst_pkg::KIND_OBJ;
      is_key    = (state_ff == ST_KEY);

      if (state_ff == ST_ERROR) begin
         ev = jst_pkg::EV_AFTER_ERROR;
      end else if (!in_value && is_space) begin
         ev = jst_pkg::EV_SKIP;
      end else begin
         case (state_ff)
            ST_INIT, ST_COLON, ST_ARR_START: begin
               if (state_ff == ST_ARR_START && c == "]") begin
                  ev       = jst_pkg::EV_ARR_CLOSE;
                  state_in = ST_VALUE_END;
                  pop      = 1'b1;
                  done_in  = done_ff | stk.one;
               end else begin
                  ev        = sv_ev;
                  state_in  = sv_st;
                  push      = sv_push;
                  push_kind = sv_arr ? jst_pkg::KIND_ARR : jst_pkg::KIND_OBJ;
                  if (sv_st == ST_STR) begin
                     esc_in = 1'b0;
                  end
                  if (sv_st == ST_LIT) begin
                     lwhich_in = sv_lw;
                     lpos_in   = 3'd1;
                  end
               end
            end
            ST_OBJ_START: begin
               if (c == "\"") begin
                  ev       = jst_pkg::EV_KEY_OPEN;
                  state_in = ST_KEY;
                  esc_in   = 1'b0;
               end else if (c == "}") begin
                  ev       = jst_pkg::EV_OBJ_CLOSE;
                  state_in = ST_VALUE_END;
                  pop      = 1'b1;
                  done_in  = done_ff | stk.one;
               end else begin
                  ev       = jst_pkg::EV_ERROR;
                  state_in = ST_ERROR;
               end
            end
            ST_KEY, ST_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  ev     = is_key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR;
                  case (c)
                     "\"", "\\", "/": data = c;
                     "b":             data = 8'h08;
                     "f":             data = 8'h0C;
                     "n":             data = 8'h0A;
                     "r":             data = 8'h0D;
                     "t":             data = 8'h09;
                     default: begin
                        data     = 8'h00;
                        ev       = jst_pkg::EV_ERROR;
                        state_in = ST_ERROR;
                     end
                  endcase
               end else if (c == "\\") begin
                  esc_in = 1'b1;
                  ev     = jst_pkg::EV_ESCAPE;
               end else if (c == "\"") begin
                  if (is_key) begin
                     ev       = jst_pkg::EV_KEY_END;
                     state_in = ST_KEY_END;
                  end else begin
                     ev       = jst_pkg::EV_STR_CLOSE;
                     state_in = ST_VALUE_END;
                     done_in  = done_ff | stk.empty;
                  end
               end else begin
                  data = c;
                  ev   = is_key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR;
               end
            end
            ST_KEY_END: begin
               if (c == ":") begin
                  ev       = jst_pkg::EV_COLON;
                  state_in = ST_COLON;
               end else begin
                  ev       = jst_pkg::EV_ERROR;
                  state_in = ST_ERROR;
               end
            end
            ST_NUM: begin
               if (c == "-" || c == "." || c == "e" || c == "+" || is_digit) begin
                  ev = jst_pkg::EV_NUM_CHAR;
               end else begin
                  // Delimiter closes the number, then is handled as a post-value byte.
                  numdone  = 1'b1;
                  done_in  = done_ff | stk.empty;
                  ev       = av_ev;
                  state_in = av_st;
                  pop      = av_pop;
                  if (av_pop) begin
                     done_in = 1'b1 & (done_ff | stk.empty | stk.one);
                  end
               end
            end
            ST_VALUE_END: begin
               ev       = av_ev;
               state_in = av_st;
               pop      = av_pop;
               if (av_pop) begin
                  done_in = done_ff | stk.one;
               end
            end
            ST_LIT: begin
               if (lpos_ff >= jst_pkg::lit_len(lwhich_ff) ||
                   jst_pkg::lit_char(lwhich_ff, lpos_ff) != c) begin
                  ev       = jst_pkg::EV_ERROR;
                  state_in = ST_ERROR;
               end else begin
                  ev      = jst_pkg::EV_LIT_CHAR;
                  lpos_in = lpos_inc;
                  if (lpos_inc == jst_pkg::lit_len(lwhich_ff)) begin
                     kind     = lwhich_ff;
                     state_in = ST_VALUE_END;
                     done_in  = done_ff | stk.empty;
                  end
               end
            end
            default: begin
               ev       = jst_pkg::EV_ERROR;
               state_in = ST_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         esc_ff    <= 1'b0;
         lpos_ff   <= 3'd0;
         lwhich_ff <= jst_pkg::LIT_NONE;
         done_ff   <= 1'b0;
      end else if (advance) begin
         state_ff  <= state_in;
         esc_ff    <= esc_in;
         lpos_ff   <= lpos_in;
         lwhich_ff <= lwhich_in;
         done_ff   <= done_in;
      end
   end

   assign stk_op.push = advance & push;
   assign stk_op.pop  = advance & pop;
   assign stk_op.kind = push_kind;

   assign result.event_res    = ev;
   assign result.data_byte    = data;
   assign result.number_done  = numdone;
   assign result.literal_kind = kind;
   assign result.error_flag   = (state_in == ST_ERROR);
   assign result.complete     = done_in;

   assign error_now = (state_ff == ST_ERROR);

endmodule

// ----- rtl/json_stream_tokenizer.sv -----
// Top level of the JSON stream tokenizer: input register, parser, stack, result register.
// A word accepted on req_ is held in the input register, then stepped into the result register that drives rsp_.
// Throughput: one byte per cycle while rsp_ready keeps the result stage draining; the grammar step and the
// stack top prefetch both work combinationally from the input register.
// Reset (synchronous, active high): parser expects an initial value, depth zero,
// no error, not complete; both register stages are emptied. Stack entries need no clear.
module json_stream_tokenizer #(
   parameter int MAX_DEPTH = jst_pkg::MAX_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [jst_pkg::BYTE_W-1:0]     req_in_byte,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [jst_pkg::EVENT_W-1:0]    rsp_event_res,
   output logic [jst_pkg::BYTE_W-1:0]     rsp_data_byte,
   output logic                           rsp_number_done,
   output logic [1:0]                     rsp_literal_kind,
   output logic [jst_pkg::DEPTH_W-1:0]    rsp_nest_depth,
   output logic                           rsp_error_flag,
   output logic                           rsp_complete
);

   localparam int SP_W = $clog2(MAX_DEPTH + 1);

   // Input register: one byte word waiting for the parser.
   logic                          in_valid_ff, in_valid_in;
   logic [jst_pkg::BYTE_W-1:0]    in_byte_ff;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   jst_pkg::result_type           out_res_ff;
   logic [jst_pkg::DEPTH_W-1:0]   out_depth_ff;

   logic                          advance;
   logic                          req_take;

   jst_pkg::stack_op_type         stk_op;
   jst_pkg::stack_status_type     stk_status;
   logic [SP_W-1:0]               depth, depth_next;
   jst_pkg::result_type           step_res;
   logic                          error_now;

   // Move the held byte through the parser whenever the result stage is free
   // or is being drained this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   // Take a new byte when the input register is empty or is emptied now.
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload until the next word is taken.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_res_ff   <= step_res;
         out_depth_ff <= jst_pkg::DEPTH_W'(depth_next);
      end
   end

   jst_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .op         (stk_op),
      .status     (stk_status),
      .depth      (depth),
      .depth_next (depth_next)
   );

   jst_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_byte   (in_byte_ff),
      .stk       (stk_status),
      .stk_op    (stk_op),
      .result    (step_res),
      .error_now (error_now)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_res_ff.event_res;
   assign rsp_data_byte    = out_res_ff.data_byte;
   assign rsp_number_done  = out_res_ff.number_done;
   assign rsp_literal_kind = out_res_ff.literal_kind;
   assign rsp_nest_depth   = out_depth_ff;
   assign rsp_error_flag   = out_res_ff.error_flag;
   assign rsp_complete     = out_res_ff.complete;

   // Error state never clears once entered.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_now |=> error_now)
      else $error("parser left the error state");

   // Nesting never exceeds the stack size.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth <= SP_W'(MAX_DEPTH))
      else $error("stack pointer beyond MAX_DEPTH");

   // A word after an error always carries the error flag.
   a_after_error_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == jst_pkg::EV_AFTER_ERROR) |-> rsp_error_flag)
      else $error("after-error word without error flag");

   // A held byte is not dropped while the result stage is blocked.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input register lost a byte");

endmodule
